@@ src/bsq_pkg.sv @@
// bsq_pkg: shared types, sizes and codes of the bounded sorted priority queue
// no dependencies; imported by every module of the block

package bsq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned COORD_BITS  = 7;

  localparam int unsigned PRI_W   = 20;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned MOVE_W  = 2;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned OCNT_W  = 7;
  localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(40);

  // register index codes
  localparam int unsigned REG_CAPACITY = 0;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP_FRONT,
    S_POP_SHIFT,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [PRI_W-1:0]      pri;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [MOVE_W-1:0]     mv;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } store_req_t;

  typedef struct packed {
    logic             valid;
    logic             pop_valid;
    entry_t           entry;
    logic [CNT_W-1:0] count;
    logic             dropped;
  } res_t;

endpackage

@@ src/bsq_store.sv @@
// bsq_store: entry memory, one write port and one registered read port
// depends on bsq_pkg

module bsq_store (
  input  logic                clk_i,
  input  bsq_pkg::store_req_t req_i,
  output bsq_pkg::entry_t     rd_data_o
);
  import bsq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/bsq_cfg.sv @@
// bsq_cfg: apb register file holding the capacity limit
// depends on bsq_pkg

module bsq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsq_pkg::PADDR_W-1:0]   paddr,
  input  logic [bsq_pkg::PDATA_W-1:0]   pwdata,
  output logic [bsq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [bsq_pkg::CAP_W-1:0]     cap_o
);
  import bsq_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] cap_d;
  logic             sel_cap;

  assign sel_cap = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_CAPACITY));
  assign pready  = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && sel_cap) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = sel_cap ? PDATA_W'(cap_q) : '0;
  assign cap_o  = cap_q;

endmodule

@@ src/bsq_seq.sv @@
// bsq_seq: sequencer with the single priority comparator; scans, shifts and pops
// depends on bsq_pkg; drives bsq_store

module bsq_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bsq_pkg::op_e              op_i,
  input  bsq_pkg::entry_t           entry_i,
  input  logic [bsq_pkg::CAP_W-1:0] cap_i,
  input  bsq_pkg::entry_t           rd_data_i,
  output bsq_pkg::store_req_t       store_req_o,
  output bsq_pkg::res_t             res_o,
  input  logic                      res_take_i
);
  import bsq_pkg::*;

  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  entry_t            ent_q, ent_d;
  logic [CNT_W-1:0]  fc_q, fc_d;
  logic              drop_q, drop_d;
  logic [CNT_W-1:0]  ncount_q, ncount_d;
  entry_t            res_ent_q, res_ent_d;
  logic              res_pop_q, res_pop_d;

  logic [EW-1:0]     cap_w;
  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W:0]    cnt_p1;
  logic              drop_in;
  logic [CNT_W-1:0]  fc_in;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  idx_p1;
  logic              less;

  // effective capacity and final count of an insert
  assign cap_w   = EW'(cap_i);
  assign eff_cap = (cap_w > EW'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_w);
  assign cnt_p1  = {1'b0, count_q} + (CNT_W+1)'(1);
  assign drop_in = cnt_p1 > {1'b0, eff_cap};
  assign fc_in   = drop_in ? count_q : cnt_p1[CNT_W-1:0];
  assign cnt_m1  = count_q - CNT_W'(1);
  assign idx_p1  = CNT_W'(idx_q) + CNT_W'(1);
  assign less    = rd_data_i.pri < ent_q.pri;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    ent_d       = ent_q;
    fc_d        = fc_q;
    drop_d      = drop_q;
    ncount_d    = ncount_q;
    res_ent_d   = res_ent_q;
    res_pop_d   = res_pop_q;
    store_req_o = '0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ent_d     = entry_i;
          res_ent_d = '0;
          res_pop_d = 1'b0;
          fc_d      = fc_in;
          if (op_i == OP_INSERT) begin
            drop_d   = drop_in;
            ncount_d = fc_in;
            if (count_q == '0) begin
              pos_d   = '0;
              state_d = S_PLACE;
            end else begin
              store_req_o.rd_en   = 1'b1;
              store_req_o.rd_addr = ADDR_W'(cnt_m1);
              idx_d               = ADDR_W'(cnt_m1);
              state_d             = S_SCAN;
            end
          end else begin
            drop_d = 1'b0;
            if (count_q == '0) begin
              ncount_d = '0;
              state_d  = S_DONE;
            end else begin
              ncount_d            = cnt_m1;
              store_req_o.rd_en   = 1'b1;
              store_req_o.rd_addr = '0;
              state_d             = S_POP_FRONT;
            end
          end
        end
      end
      // walk up from the tail, moving lower entries down by one
      S_SCAN: begin
        if (less) begin
          store_req_o.wr_en   = idx_p1 < fc_q;
          store_req_o.wr_addr = ADDR_W'(idx_p1);
          store_req_o.wr_data = rd_data_i;
          if (idx_q == '0) begin
            pos_d   = '0;
            state_d = S_PLACE;
          end else begin
            store_req_o.rd_en   = 1'b1;
            store_req_o.rd_addr = idx_q - ADDR_W'(1);
            idx_d               = idx_q - ADDR_W'(1);
          end
        end else begin
          pos_d   = idx_p1;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        store_req_o.wr_en   = pos_q < fc_q;
        store_req_o.wr_addr = ADDR_W'(pos_q);
        store_req_o.wr_data = ent_q;
        state_d             = S_DONE;
      end
      S_POP_FRONT: begin
        res_ent_d = rd_data_i;
        res_pop_d = 1'b1;
        if (count_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end else begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = ADDR_W'(1);
          idx_d               = ADDR_W'(1);
          state_d             = S_POP_SHIFT;
        end
      end
      S_POP_SHIFT: begin
        store_req_o.wr_en   = 1'b1;
        store_req_o.wr_addr = idx_q - ADDR_W'(1);
        store_req_o.wr_data = rd_data_i;
        if (idx_p1 < count_q) begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = ADDR_W'(idx_p1);
          idx_d               = ADDR_W'(idx_p1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          count_d = ncount_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    ent_q     <= ent_d;
    fc_q      <= fc_d;
    drop_q    <= drop_d;
    ncount_q  <= ncount_d;
    res_ent_q <= res_ent_d;
    res_pop_q <= res_pop_d;
  end

  assign res_o.valid     = (state_q == S_DONE);
  assign res_o.pop_valid = res_pop_q;
  assign res_o.entry     = res_ent_q;
  assign res_o.count     = ncount_q;
  assign res_o.dropped   = drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q))
    else $error("scan index beyond stored entries");

  a_insert_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN || state_q == S_PLACE) && store_req_o.wr_en)
      |-> (CNT_W'(store_req_o.wr_addr) < fc_q))
    else $error("insert writes past the kept entries");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_pop_q) |-> (count_q != '0 && ncount_q == count_q - CNT_W'(1)))
    else $error("pop result without a stored entry");

endmodule

@@ src/bounded_sorted_priority_queue_top.sv @@
// bounded_sorted_priority_queue_top: one item in flight at a time, set by the single read and
// single write port of the entry memory scanned one entry a cycle
// the next item may transfer in while a result waits in the output register
// reset clears the count to zero and the capacity limit to 40; entry memory is not cleared
// depends on bsq_pkg, bsq_cfg, bsq_seq, bsq_store

module bounded_sorted_priority_queue_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [bsq_pkg::PRI_W-1:0]           priority_req_i,
  input  logic [bsq_pkg::POS_W-1:0]           pos_x_i,
  input  logic [bsq_pkg::POS_W-1:0]           pos_y_i,
  input  logic [bsq_pkg::MOVE_W-1:0]          move_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pop_valid_o,
  output logic [bsq_pkg::PRI_W-1:0]           out_priority_o,
  output logic [bsq_pkg::POS_W-1:0]           out_x_o,
  output logic [bsq_pkg::POS_W-1:0]           out_y_o,
  output logic [bsq_pkg::MOVE_W-1:0]          out_move_o,
  output logic [bsq_pkg::OCNT_W-1:0]          entry_count_o,
  output logic                                was_dropped_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsq_pkg::PADDR_W-1:0]         paddr,
  input  logic [bsq_pkg::PDATA_W-1:0]         pwdata,
  output logic [bsq_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import bsq_pkg::*;

  logic [CAP_W-1:0] cap;
  entry_t           in_entry;
  entry_t           rd_data;
  store_req_t       store_req;
  res_t             res;
  res_t             out_res_q;
  logic             out_valid_q;
  logic             out_free;

  assign in_entry.pri = priority_req_i;
  assign in_entry.x   = COORD_BITS'(pos_x_i);
  assign in_entry.y   = COORD_BITS'(pos_y_i);
  assign in_entry.mv  = move_code_i;

  bsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  bsq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_e'(func_i)),
    .entry_i     (in_entry),
    .cap_i       (cap),
    .rd_data_i   (rd_data),
    .store_req_o (store_req),
    .res_o       (res),
    .res_take_i  (out_free)
  );

  bsq_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pop_valid_o    = out_res_q.pop_valid;
  assign out_priority_o = out_res_q.entry.pri;
  assign out_x_o        = POS_W'(out_res_q.entry.x);
  assign out_y_o        = POS_W'(out_res_q.entry.y);
  assign out_move_o     = out_res_q.entry.mv;
  assign entry_count_o  = OCNT_W'(out_res_q.count);
  assign was_dropped_o  = out_res_q.dropped;

endmodule
